// ----- hw/rtl/otem_pkg.sv -----
// ----------------------------------------------------------------------------
// otem_pkg
// Shared types and defaults for the identifier table exact-match search.
// ----------------------------------------------------------------------------
package otem_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int MAX_OID_LEN_DEF = 32;
    localparam int PREFIX_LEN_DEF  = 8;

    localparam int CFG_W   = 9;
    localparam int INDEX_W = 8;
    localparam int POS_IN_W = 5;
    localparam int VALUE_W = 32;

    // Item kinds carried in the input tuser.
    typedef enum logic [1:0] {
        MODE_LEN   = 2'd0,
        MODE_SUB   = 2'd1,
        MODE_OFF   = 2'd2,
        MODE_QUERY = 2'd3
    } otem_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LEN,
        ST_CMP,
        ST_OFFS,
        ST_DONE
    } otem_state_t;

    // Write enables of the three table memories.
    typedef struct packed {
        logic len;
        logic sub;
        logic off;
    } otem_twe_t;

    // Status of a query as it stands after its final item.
    typedef struct packed {
        logic too_long;
        logic too_few;
    } otem_qstat_t;

endpackage

// ----- hw/rtl/oid_table_exact_match_search.sv -----
// ----------------------------------------------------------------------------
// oid_table_exact_match_search
// Exact-match lookup of an object identifier in a loadable table.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream. tuser selects the kind: load an entry's
// length, one sub-identifier, its data offset, or stream one query
// sub-identifier (tlast marks the query's final item). Load items and
// query items without tlast are taken while the block is idle and return nothing.
// The final query item starts a scan of entries 0 to entry_count-1, capped at
// MAX_ENTRIES-1, over the table memories: each entry's length is examined and,
// in an entry of matching length, its sub-identifiers are compared one by one
// (states START, LEN, CMP, OFFS when an entry matches, DONE), after which one
// result item is loaded into the m_ output register. The scan stops at the
// first matching entry. A query that is too long or too short, or an
// entry_count of zero, skips the scan and goes from START straight to DONE.
// The block takes no new item during the scan; a result waiting on m_tready
// holds the next scan at its end but not the loads that follow it. The user must
// write entry_count on the cfg_ channel only while the block is idle; it is unchecked.
// Reset clears the control state, the query counter and entry_count; the
// table memories are not cleared and must be loaded before they are searched.
// ----------------------------------------------------------------------------
module oid_table_exact_match_search
    import otem_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int MAX_OID_LEN = MAX_OID_LEN_DEF,
    parameter int PREFIX_LEN  = PREFIX_LEN_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // Configuration: entry_count.
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    // Input stream.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [47:0]      s_tdata,   // entry_index[7:0], position[12:8], value[44:13]
    input  logic [1:0]       s_tuser,   // mode[1:0]
    input  logic             s_tlast,   // last
    // Result stream.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,   // match_index[7:0], data_offset[39:8]
    output logic [1:0]       m_tuser    // found[0], too_long[1]
);

    localparam int ENT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ENTC_W = ENT_W + 1;
    localparam int POS_W  = (MAX_OID_LEN > 1) ? $clog2(MAX_OID_LEN) : 1;
    localparam int LEN_W  = $clog2(MAX_OID_LEN + 2);
    localparam int QL_W   = $clog2(MAX_OID_LEN + 1);

    otem_state_t state_reg, state_next;

    logic [CFG_W-1:0]   entry_count_reg;
    logic [ENTC_W-1:0]  limit;

    logic               accept;
    otem_mode_t         mode;
    logic [INDEX_W-1:0] in_index;
    logic [POS_IN_W-1:0] in_pos;
    logic [VALUE_W-1:0] in_value;
    logic               idx_ok;
    logic               pos_ok;
    logic               q_wr;
    logic               q_final;
    otem_twe_t          twe;

    logic [ENTC_W-1:0]  ent_reg, ent_next, ent_inc;
    logic [POS_W-1:0]   sub_reg, sub_next;
    logic [POS_W:0]     sub_inc;
    logic [QL_W-1:0]    qlen_reg;
    otem_qstat_t        qstat_reg;
    logic               res_found_reg, res_found_next;
    logic [VALUE_W-1:0] res_off_reg, res_off_next;

    logic [ENT_W-1:0]   rd_ent;
    logic [POS_W-1:0]   rd_pos;
    logic [LEN_W-1:0]   len_rd;
    logic [VALUE_W-1:0] off_rd;
    logic [VALUE_W-1:0] sub_rd;
    logic [VALUE_W-1:0] q_rd;
    logic [QL_W-1:0]    q_len;
    otem_qstat_t        q_stat;

    logic               len_hit;
    logic               sub_hit;
    logic               last_sub;
    logic               scan_end;
    logic               out_free;

    logic               m_tvalid_reg;
    logic               m_found_reg;
    logic [INDEX_W-1:0] m_idx_reg;
    logic [VALUE_W-1:0] m_off_reg;
    logic               m_tl_reg;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign mode      = otem_mode_t'(s_tuser);
    assign in_index  = s_tdata[7:0];
    assign in_pos    = s_tdata[12:8];
    assign in_value  = s_tdata[44:13];

    assign idx_ok  = 32'(in_index) < MAX_ENTRIES;
    assign pos_ok  = 32'(in_pos) < MAX_OID_LEN;
    assign q_wr    = accept && (mode == MODE_QUERY);
    assign q_final = q_wr && s_tlast;

    always_comb begin
        twe.len = accept && (mode == MODE_LEN) && idx_ok;
        twe.sub = accept && (mode == MODE_SUB) && idx_ok && pos_ok;
        twe.off = accept && (mode == MODE_OFF) && idx_ok;
    end

    assign limit = (32'(entry_count_reg) > MAX_ENTRIES) ? ENTC_W'(MAX_ENTRIES)
                                                        : ENTC_W'(entry_count_reg);

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    otem_table #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_OID_LEN (MAX_OID_LEN)
    ) u_table (
        .aclk    (aclk),
        .wr_we   (twe),
        .wr_ent  (ENT_W'(in_index)),
        .wr_pos  (POS_W'(in_pos)),
        .wr_data (in_value),
        .rd_ent  (rd_ent),
        .rd_pos  (rd_pos),
        .len_rd  (len_rd),
        .off_rd  (off_rd),
        .sub_rd  (sub_rd)
    );

    otem_query #(
        .MAX_OID_LEN (MAX_OID_LEN),
        .PREFIX_LEN  (PREFIX_LEN)
    ) u_query (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr),
        .wr_last (s_tlast),
        .wr_data (in_value),
        .rd_pos  (rd_pos),
        .q_rd    (q_rd),
        .q_len   (q_len),
        .q_stat  (q_stat)
    );

    // ------------------------------------------------------------------
    // Scan control
    // ------------------------------------------------------------------
    assign ent_inc  = ent_reg + 1'b1;
    assign sub_inc  = {1'b0, sub_reg} + 1'b1;
    assign len_hit  = (len_rd == LEN_W'(qlen_reg));
    assign sub_hit  = (sub_rd == q_rd);
    assign last_sub = (32'(sub_inc) == 32'(qlen_reg));
    assign scan_end = (ent_inc >= limit);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_final) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (qstat_reg.too_long || qstat_reg.too_few || (limit == '0)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                if (len_hit) begin
                    state_next = (qlen_reg == '0) ? ST_OFFS : ST_CMP;
                end else begin
                    state_next = scan_end ? ST_DONE : ST_LEN;
                end
            end
            ST_CMP: begin
                if (sub_hit) begin
                    state_next = last_sub ? ST_OFFS : ST_CMP;
                end else begin
                    state_next = scan_end ? ST_DONE : ST_LEN;
                end
            end
            ST_OFFS: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Read addresses are issued in the cycle before the data they return.
    always_comb begin
        ent_next       = ent_reg;
        sub_next       = sub_reg;
        rd_ent         = ent_reg[ENT_W-1:0];
        rd_pos         = sub_reg;
        res_found_next = res_found_reg;
        res_off_next   = res_off_reg;
        unique case (state_reg)
            ST_IDLE: begin
                ent_next       = '0;
                res_found_next = 1'b0;
                res_off_next   = '0;
            end
            ST_START: begin
                rd_ent = '0;
            end
            ST_LEN: begin
                if (len_hit) begin
                    rd_pos   = '0;
                    sub_next = '0;
                end else begin
                    ent_next = ent_inc;
                    rd_ent   = ent_inc[ENT_W-1:0];
                end
            end
            ST_CMP: begin
                if (sub_hit) begin
                    if (!last_sub) begin
                        sub_next = sub_inc[POS_W-1:0];
                        rd_pos   = sub_inc[POS_W-1:0];
                    end
                end else begin
                    ent_next = ent_inc;
                    rd_ent   = ent_inc[ENT_W-1:0];
                end
            end
            ST_OFFS: begin
                res_found_next = 1'b1;
                res_off_next   = off_rd;
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                entry_count_reg <= cfg_data;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg       <= ent_next;
        sub_reg       <= sub_next;
        res_found_reg <= res_found_next;
        res_off_reg   <= res_off_next;
        if (q_final) begin
            qlen_reg  <= q_len;
            qstat_reg <= q_stat;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_found_reg <= res_found_reg;
            m_idx_reg   <= res_found_reg ? INDEX_W'(ent_reg) : '0;
            m_off_reg   <= res_off_reg;
            m_tl_reg    <= qstat_reg.too_long;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_off_reg, m_idx_reg};
    assign m_tuser  = {m_tl_reg, m_found_reg};

endmodule

// ----- hw/rtl/otem_table.sv -----
// ----------------------------------------------------------------------------
// otem_table
// Entry memories: lengths, sub-identifiers and data offsets, one write port
// and registered reads.
// ----------------------------------------------------------------------------
module otem_table
    import otem_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int MAX_OID_LEN = MAX_OID_LEN_DEF,
    localparam int ENT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int POS_W = (MAX_OID_LEN > 1) ? $clog2(MAX_OID_LEN) : 1,
    localparam int LEN_W = $clog2(MAX_OID_LEN + 2)
) (
    input  logic               aclk,
    input  otem_twe_t          wr_we,
    input  logic [ENT_W-1:0]   wr_ent,
    input  logic [POS_W-1:0]   wr_pos,
    input  logic [VALUE_W-1:0] wr_data,
    input  logic [ENT_W-1:0]   rd_ent,
    input  logic [POS_W-1:0]   rd_pos,
    output logic [LEN_W-1:0]   len_rd,
    output logic [VALUE_W-1:0] off_rd,
    output logic [VALUE_W-1:0] sub_rd
);

    localparam int SUB_DEPTH = MAX_ENTRIES * (2 ** POS_W);

    logic [LEN_W-1:0]   len_mem [MAX_ENTRIES];
    logic [VALUE_W-1:0] off_mem [MAX_ENTRIES];
    logic [VALUE_W-1:0] sub_mem [SUB_DEPTH];

    logic [LEN_W-1:0] len_wr;

    // Lengths beyond the maximum are kept as one more than it, which never matches.
    assign len_wr = (wr_data > VALUE_W'(MAX_OID_LEN)) ? LEN_W'(MAX_OID_LEN + 1)
                                                      : LEN_W'(wr_data);

    always_ff @(posedge aclk) begin
        if (wr_we.len) begin
            len_mem[wr_ent] <= len_wr;
        end
        if (wr_we.off) begin
            off_mem[wr_ent] <= wr_data;
        end
        if (wr_we.sub) begin
            sub_mem[{wr_ent, wr_pos}] <= wr_data;
        end
        len_rd <= len_mem[rd_ent];
        off_rd <= off_mem[rd_ent];
        sub_rd <= sub_mem[{rd_ent, rd_pos}];
    end

endmodule

// ----- hw/rtl/otem_query.sv -----
// ----------------------------------------------------------------------------
// otem_query
// Query buffer: stores sub-identifiers after the prefix, counts items and
// flags overflow.
// ----------------------------------------------------------------------------
module otem_query
    import otem_pkg::*;
#(
    parameter int MAX_OID_LEN = MAX_OID_LEN_DEF,
    parameter int PREFIX_LEN  = PREFIX_LEN_DEF,
    localparam int POS_W = (MAX_OID_LEN > 1) ? $clog2(MAX_OID_LEN) : 1,
    localparam int QL_W  = $clog2(MAX_OID_LEN + 1),
    localparam int CNT_W = $clog2(PREFIX_LEN + MAX_OID_LEN + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic               wr_last,
    input  logic [VALUE_W-1:0] wr_data,
    input  logic [POS_W-1:0]   rd_pos,
    output logic [VALUE_W-1:0] q_rd,
    output logic [QL_W-1:0]    q_len,
    output otem_qstat_t        q_stat
);

    logic [VALUE_W-1:0] q_mem [MAX_OID_LEN];

    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next;
    logic [CNT_W-1:0] k;
    logic             past_prefix;
    logic             store_en;
    logic             ovf_set;
    logic [CNT_W-1:0] cnt_inc;

    always_comb begin
        past_prefix = 32'(count_reg) >= PREFIX_LEN;
        k           = count_reg - CNT_W'(PREFIX_LEN);
        store_en    = past_prefix && (32'(k) < MAX_OID_LEN);
        ovf_set     = past_prefix && !(32'(k) < MAX_OID_LEN);
        cnt_inc     = (32'(count_reg) < PREFIX_LEN + MAX_OID_LEN) ? count_reg + 1'b1
                                                                  : count_reg;
    end

    // The status reflects the query including the item being written now.
    always_comb begin
        q_stat.too_long = overflow_reg | ovf_set;
        q_stat.too_few  = 32'(cnt_inc) < PREFIX_LEN;
        q_len           = QL_W'(cnt_inc - CNT_W'(PREFIX_LEN));
    end

    always_comb begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (wr_en) begin
            if (wr_last) begin
                count_next    = '0;
                overflow_next = 1'b0;
            end else begin
                count_next    = cnt_inc;
                overflow_next = overflow_reg | ovf_set;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && store_en) begin
            q_mem[POS_W'(k)] <= wr_data;
        end
        q_rd <= q_mem[rd_pos];
    end

endmodule

// ----- sim/tb_oid_table_exact_match_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oid_table_exact_match_search
// Self-checking bench for the identifier table exact-match search.
// ----------------------------------------------------------------------------
// Loads a table of identifiers over the s_ stream and streams queries against
// it. A local copy of the table and of the query state predicts every lookup
// result; each result taken from the m_ stream is checked field by field.
// entry_count is swept over several settings, both streams stall at random,
// and every entry inside the searched range is kept fully loaded.
// ----------------------------------------------------------------------------
module tb_oid_table_exact_match_search;
    import otem_pkg::*;

    localparam int ENTRIES     = MAX_ENTRIES_DEF;
    localparam int OID_LEN     = MAX_OID_LEN_DEF;
    localparam int PREFIX      = PREFIX_LEN_DEF;
    localparam int IDLE_PCT    = 33;
    localparam int STALL_LIMIT = 50000;
    localparam int PHASE_ITEMS = 40;
    localparam int MAX_PRINTS  = 100;
    localparam bit [5:0] LEN_NEVER = 6'(OID_LEN + 1);

    typedef struct packed {
        otem_mode_t  mode;
        logic [7:0]  idx;
        logic [4:0]  pos;
        logic [31:0] value;
        logic        last;
    } search_item_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  match_index;
        logic [31:0] data_offset;
        logic        too_long;
    } lookup_result_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [47:0]      s_tdata   = '0;   // entry_index[7:0], position[12:8], value[44:13]
    logic [1:0]       s_tuser   = '0;   // mode[1:0]
    logic             s_tlast   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [39:0]      m_tdata;          // match_index[7:0], data_offset[39:8]
    logic [1:0]       m_tuser;          // found[0], too_long[1]

    // Predicted table and query state.
    bit [5:0]         tbl_len [ENTRIES];
    bit [31:0]        tbl_sub [ENTRIES][OID_LEN];
    bit [31:0]        tbl_off [ENTRIES];
    bit [31:0]        sub_loaded [ENTRIES];
    bit [31:0]        q_sub [OID_LEN];
    int unsigned      q_cnt;
    bit               q_ovf;
    bit [CFG_W-1:0]   count_reg;

    lookup_result_t   pending_lookups [$];
    logic [31:0]      query_tail [$];
    int               err_count;
    int               items_sent;
    int               stall_cycles;
    bit               no_idle;

    always #1 aclk = ~aclk;

    oid_table_exact_match_search i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Applies one item to the predicted state; returns 1 when it yields a result.
    function automatic bit oid_lookup_step(input search_item_t it,
                                           output lookup_result_t res);
        int unsigned qlen;
        int unsigned lim;
        int unsigned i;
        int unsigned j;
        bit          hit;
        res = '0;
        if (it.mode != MODE_QUERY) begin
            case (it.mode)
                MODE_LEN: tbl_len[it.idx] = (it.value > OID_LEN) ? LEN_NEVER : it.value[5:0];
                MODE_SUB: tbl_sub[it.idx][it.pos] = it.value;
                default:  tbl_off[it.idx] = it.value;
            endcase
            return 1'b0;
        end
        if (q_cnt >= PREFIX) begin
            if (q_cnt - PREFIX < OID_LEN) begin
                q_sub[q_cnt - PREFIX] = it.value;
            end else begin
                q_ovf = 1'b1;
            end
        end
        if (q_cnt < PREFIX + OID_LEN) q_cnt++;
        if (!it.last) return 1'b0;

        lim = (count_reg > ENTRIES) ? ENTRIES : count_reg;
        if (!q_ovf && q_cnt >= PREFIX) begin
            qlen = q_cnt - PREFIX;
            for (i = 0; i < lim && !res.found; i++) begin
                if (tbl_len[i] == qlen) begin
                    hit = 1'b1;
                    for (j = 0; j < qlen; j++) begin
                        if (tbl_sub[i][j] != q_sub[j]) hit = 1'b0;
                    end
                    if (hit) begin
                        res.found       = 1'b1;
                        res.match_index = i[7:0];
                        res.data_offset = tbl_off[i];
                    end
                end
            end
        end
        res.too_long = q_ovf;
        q_cnt = 0;
        q_ovf = 1'b0;
        return 1'b1;
    endfunction

    // Sub-identifier values come mostly from a tiny pool so that entries collide.
    function automatic logic [31:0] rand_subid();
        if ($urandom_range(99) < 70) return $urandom_range(3);
        return $urandom();
    endfunction

    function automatic logic [31:0] rand_len_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return $urandom_range(2);
        if (r < 85) return $urandom_range(8, 3);
        if (r < 95) return $urandom_range(OID_LEN, 9);
        return $urandom_range(32'hFFFF_FFFF, OID_LEN + 1);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_PRINTS) begin
            $display("%0t ERROR %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
        end
        err_count++;
    endtask

    task automatic send_item(input otem_mode_t mode, input logic [7:0] idx,
                             input logic [4:0] pos, input logic [31:0] value,
                             input logic last);
        search_item_t   it;
        lookup_result_t res;
        it = '{mode: mode, idx: idx, pos: pos, value: value, last: last};
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, value, pos, idx};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (oid_lookup_step(it, res)) pending_lookups.push_back(res);
        if (mode == MODE_SUB) sub_loaded[idx][pos] = 1'b1;
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic stream_stop();
        s_tvalid <= 1'b0;
    endtask

    // Writes a length and then loads every sub-identifier it exposes that was
    // never written, so that a scan never reads an unloaded location.
    task automatic write_length(input logic [7:0] e, input logic [31:0] v);
        int p;
        send_item(MODE_LEN, e, 5'($urandom_range(31)), v, 1'($urandom_range(1)));
        for (p = 0; p < tbl_len[e] && p < OID_LEN; p++) begin
            if (!sub_loaded[e][p]) begin
                send_item(MODE_SUB, e, 5'(p), rand_subid(), 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic write_entry_count(input logic [CFG_W-1:0] v);
        stream_stop();
        while (pending_lookups.size() != 0) @(negedge aclk);
        // A trailing load item may still be in flight.
        repeat (8) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        count_reg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sends n_prefix prefix items and then query_tail; the final item carries tlast.
    task automatic send_query(input int n_prefix);
        int i;
        int n_tail;
        n_tail = query_tail.size();
        for (i = 0; i < n_prefix; i++) begin
            send_item(MODE_QUERY, 8'($urandom_range(ENTRIES - 1)), 5'($urandom_range(31)),
                      $urandom(), (i == n_prefix - 1) && (n_tail == 0));
        end
        for (i = 0; i < n_tail; i++) begin
            send_item(MODE_QUERY, 8'($urandom_range(ENTRIES - 1)), 5'($urandom_range(31)),
                      query_tail[i], i == n_tail - 1);
        end
    endtask

    task automatic test_empty_table();
        int i;
        write_entry_count(0);
        query_tail.delete();
        send_query(PREFIX);
        send_query(3);
        for (i = 0; i < OID_LEN + 1; i++) query_tail.push_back($urandom());
        send_query(PREFIX);
    endtask

    task automatic test_directed_lookups();
        int i;
        send_item(MODE_OFF, 0, 0, 32'hFFFF_FFFF, 1'b1);
        write_length(0, 32'hFFFF_FFFF);
        for (i = 1; i <= 2; i++) begin
            send_item(MODE_SUB, 8'(i), 0, 32'hDEAD_0001, 1'b0);
            send_item(MODE_SUB, 8'(i), 1, 32'h0, 1'b1);
            send_item(MODE_OFF, 8'(i), 0, 32'h11 * i, 1'b0);
            write_length(8'(i), 2);
        end
        send_item(MODE_OFF, 3, 0, 32'h0, 1'b0);
        write_length(3, 0);
        for (i = 0; i < OID_LEN; i++) begin
            send_item(MODE_SUB, 4, 5'(i), (i % 2 == 0) ? 32'hFFFF_FFFF : i, 1'b0);
        end
        send_item(MODE_OFF, 4, 31, 32'h8000_0000, 1'b1);
        write_length(4, OID_LEN);
        write_entry_count(5);

        // Two identical entries: the lower index must win.
        query_tail = '{32'hDEAD_0001, 32'h0};
        send_query(PREFIX);
        query_tail.delete();
        send_query(PREFIX);
        for (i = 0; i < OID_LEN; i++) query_tail.push_back(tbl_sub[4][i]);
        send_query(PREFIX);
        query_tail = '{32'hDEAD_0001, 32'h1};
        send_query(PREFIX);

        // The zero-length entry now lies outside the searched range.
        write_entry_count(2);
        query_tail.delete();
        send_query(PREFIX);
    endtask

    // Mostly short entries keep the fill cheap; it runs without idle cycles.
    task automatic test_fill_table();
        int e;
        no_idle = 1'b1;
        for (e = 5; e < ENTRIES; e++) begin
            send_item(MODE_OFF, 8'(e), 5'($urandom_range(31)), $urandom(),
                      1'($urandom_range(1)));
            write_length(8'(e), ($urandom_range(99) < 95) ? 32'($urandom_range(1))
                                                          : rand_len_value());
        end
        no_idle = 1'b0;
    endtask

    task automatic random_query();
        int unsigned r;
        int unsigned lim;
        int          e;
        int          i;
        int          n;
        query_tail.delete();
        r   = $urandom_range(99);
        lim = (count_reg > ENTRIES) ? ENTRIES : count_reg;
        if (r < 10) begin
            send_query($urandom_range(PREFIX - 1, 1));
            return;
        end
        if (r < 18) begin
            n = $urandom_range(OID_LEN + 4, OID_LEN + 1);
            for (i = 0; i < n; i++) query_tail.push_back(rand_subid());
        end else if (r < 75 && lim > 0) begin
            // Copy a searched entry, sometimes with one sub-identifier or the length off.
            e = $urandom_range(lim - 1);
            for (i = 0; i < tbl_len[e] && i < OID_LEN; i++) query_tail.push_back(tbl_sub[e][i]);
            case ($urandom_range(7))
                0: if (query_tail.size() > 0)
                       query_tail[$urandom_range(query_tail.size() - 1)] = rand_subid();
                1: query_tail.push_back(rand_subid());
                2: if (query_tail.size() > 0) void'(query_tail.pop_back());
                default: ;
            endcase
        end else begin
            n = $urandom_range(4);
            for (i = 0; i < n; i++) query_tail.push_back(rand_subid());
        end
        send_query(PREFIX);
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] counts [8];
        int               ph;
        int               start;
        int unsigned      r;
        counts = '{9'd256, 9'd1, 9'd511, 9'd257, 9'd0, 9'd255, 9'd128,
                   CFG_W'($urandom_range(511))};
        for (ph = 0; ph < 8; ph++) begin
            write_entry_count(counts[ph]);
            no_idle = (ph == 2);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 12) begin
                    write_length(8'($urandom_range(ENTRIES - 1)), rand_len_value());
                end else if (r < 20) begin
                    send_item(MODE_SUB, 8'($urandom_range(ENTRIES - 1)),
                              5'($urandom_range(31)), rand_subid(), 1'($urandom_range(1)));
                end else if (r < 25) begin
                    send_item(MODE_OFF, 8'($urandom_range(ENTRIES - 1)),
                              5'($urandom_range(31)), $urandom(), 1'($urandom_range(1)));
                end else begin
                    random_query();
                end
            end
            no_idle = 1'b0;
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch("result with no lookup pending", {22'b0, m_tuser, m_tdata[7:0]}, 0);
            end else begin
                want = pending_lookups.pop_front();
                if (m_tuser[0] != want.found)
                    report_mismatch("found", 32'(m_tuser[0]), 32'(want.found));
                if (m_tdata[7:0] != want.match_index)
                    report_mismatch("match_index", 32'(m_tdata[7:0]), 32'(want.match_index));
                if (m_tdata[39:8] != want.data_offset)
                    report_mismatch("data_offset", m_tdata[39:8], want.data_offset);
                if (m_tuser[1] != want.too_long)
                    report_mismatch("too_long", 32'(m_tuser[1]), 32'(want.too_long));
            end
        end
    end

    // Ends the run when no item moves on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("tb_oid_table_exact_match_search: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_empty_table();
        test_directed_lookups();
        test_fill_table();
        test_random_phases();
        stream_stop();
        while (pending_lookups.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        if (err_count == 0) begin
            $display("tb_oid_table_exact_match_search: PASS");
        end else begin
            $display("tb_oid_table_exact_match_search: FAIL");
        end
        $finish;
    end

endmodule
